[rtl/core/tge_pkg.sv]
// ----------------------------------------------------------------------------
// tge_pkg
// Shared types, constants and helper functions of the trackpad gesture engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tge_pkg;

    localparam int COORD_BITS  = 12;
    localparam int PANEL_SCALE = 3;
    localparam int TIME_BITS   = 32;
    localparam int CUR_BITS    = 10;
    localparam int HOLD_BITS   = 16;
    localparam int THR_BITS    = 8;
    localparam int SIZE_BITS   = 11;
    localparam int KIND_BITS   = 2;

    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    localparam int MAX_EVENTS  = 3;
    localparam int CNT_BITS    = 2;

    localparam int RST_HOLD    = 150;
    localparam int RST_THR     = 5;
    localparam int RST_WIDTH   = 426;
    localparam int RST_HEIGHT  = 240;
    localparam int RST_CUR_X   = RST_WIDTH / 2;
    localparam int RST_CUR_Y   = RST_HEIGHT / 2;

    localparam int SIZE_MAX    = 1 << CUR_BITS;

    localparam int DIV_SHIFT   = COORD_BITS + 3;
    localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + PANEL_SCALE - 1) / PANEL_SCALE;
    localparam int RECIP_BITS  = $clog2(DIV_RECIP + 1);
    localparam int PROD_BITS   = COORD_BITS + RECIP_BITS;

    typedef enum logic [1:0] {
        REG_HOLD   = 2'd0,
        REG_THR    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic [KIND_BITS-1:0] {
        EV_MOVE = 2'd0,
        EV_DOWN = 2'd1,
        EV_UP   = 2'd2
    } ev_kind_t;

    typedef struct packed {
        logic [HOLD_BITS-1:0] hold_time_ms;
        logic [THR_BITS-1:0]  move_threshold;
        logic [SIZE_BITS-1:0] screen_width;
        logic [SIZE_BITS-1:0] screen_height;
    } cfg_t;

    typedef struct packed {
        ev_kind_t            kind;
        logic [CUR_BITS-1:0] x;
        logic [CUR_BITS-1:0] y;
    } event_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]          count;
        event_t [MAX_EVENTS-1:0]      ev;
    } bundle_t;

    function automatic logic [CUR_BITS-1:0] axis_limit(input logic [SIZE_BITS-1:0] size);
        logic [CUR_BITS-1:0] lim;
        if (size == '0) begin
            lim = '0;
        end else if (size > SIZE_BITS'(SIZE_MAX)) begin
            lim = CUR_BITS'(SIZE_MAX - 1);
        end else begin
            lim = CUR_BITS'(size - SIZE_BITS'(1));
        end
        return lim;
    endfunction

    // truncate toward zero: divide magnitude by reciprocal multiply, restore sign
    function automatic logic signed [COORD_BITS:0] scale_div(
        input logic signed [COORD_BITS:0] d
    );
        logic [COORD_BITS-1:0] mag;
        logic [PROD_BITS-1:0]  prod;
        logic [COORD_BITS-1:0] q;
        logic signed [COORD_BITS:0] qs;
        mag  = d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
        prod = PROD_BITS'(mag) * PROD_BITS'(DIV_RECIP);
        q    = COORD_BITS'(prod >> DIV_SHIFT);
        qs   = $signed({1'b0, q});
        return d[COORD_BITS] ? -qs : qs;
    endfunction

endpackage

`default_nettype wire

[rtl/core/trackpad_gesture_engine_unit.sv]
// ----------------------------------------------------------------------------
// trackpad_gesture_engine_unit
// Relative-motion trackpad gesture decoder: touch samples in, pointer events out.
// ----------------------------------------------------------------------------
// Each accepted touch sample is registered, decoded combinationally against the
// gesture state, and its events (none to three: tap gives move, down, up; a
// hold gives move and down, possibly followed by a cursor move; a release of
// a drag gives up) are loaded into an event bundle register that drains one
// beat per cycle on the m_ channel while m_ready is high, with m_last_event on
// the final beat of a sample. The input register accepts the next sample while
// a bundle is still draining.
// ----------------------------------------------------------------------------
`default_nettype none

module trackpad_gesture_engine_unit
    import tge_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_touching,
    input  wire logic [COORD_BITS-1:0] s_panel_x,
    input  wire logic [COORD_BITS-1:0] s_panel_y,
    input  wire logic [TIME_BITS-1:0]  s_time_ms,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [KIND_BITS-1:0]       m_event_kind,
    output logic [CUR_BITS-1:0]        m_cursor_x,
    output logic [CUR_BITS-1:0]        m_cursor_y,
    output logic                       m_last_event,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [DATA_BITS-1:0]  pwdata,
    output logic      [DATA_BITS-1:0]  prdata,
    output logic                       pready
);

    cfg_t                  cfg;
    bundle_t               core_bundle;

    logic                  in_vld_reg;
    logic                  in_touch_reg;
    logic [COORD_BITS-1:0] in_x_reg;
    logic [COORD_BITS-1:0] in_y_reg;
    logic [TIME_BITS-1:0]  in_time_reg;

    logic                  bun_vld_reg, bun_vld_next;
    bundle_t               bun_reg,     bun_next;
    logic [CNT_BITS-1:0]   slot_reg,    slot_next;

    logic                  out_last;
    logic                  out_fire;
    logic                  drain;
    logic                  adv;
    event_t                cur_ev;

    tge_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tge_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step     (adv),
        .touching (in_touch_reg),
        .tx       (in_x_reg),
        .ty       (in_y_reg),
        .now      (in_time_reg),
        .bundle   (core_bundle)
    );

    assign out_last = slot_reg == (bun_reg.count - CNT_BITS'(1));
    assign out_fire = bun_vld_reg && m_ready;
    assign drain    = out_fire && out_last;
    assign adv      = in_vld_reg && (!bun_vld_reg || drain);
    assign s_ready  = !in_vld_reg || adv;

    assign cur_ev       = bun_reg.ev[slot_reg];
    assign m_valid      = bun_vld_reg;
    assign m_event_kind = cur_ev.kind;
    assign m_cursor_x   = cur_ev.x;
    assign m_cursor_y   = cur_ev.y;
    assign m_last_event = out_last;

    always_comb begin
        bun_vld_next = bun_vld_reg;
        bun_next     = bun_reg;
        slot_next    = slot_reg;
        if (adv) begin
            bun_vld_next = core_bundle.count != '0;
            bun_next     = core_bundle;
            slot_next    = '0;
        end else if (out_fire) begin
            if (out_last) begin
                bun_vld_next = 1'b0;
            end else begin
                slot_next = slot_reg + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            bun_vld_reg <= 1'b0;
            slot_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (adv) begin
                in_vld_reg <= 1'b0;
            end
            bun_vld_reg <= bun_vld_next;
            slot_reg    <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_touch_reg <= s_touching;
            in_x_reg     <= s_panel_x;
            in_y_reg     <= s_panel_y;
            in_time_reg  <= s_time_ms;
        end
        bun_reg <= bun_next;
    end

endmodule

`default_nettype wire

[rtl/core/tge_regs.sv]
// ----------------------------------------------------------------------------
// tge_regs
// APB-style configuration registers: hold time, threshold, screen size.
// ----------------------------------------------------------------------------
`default_nettype none

module tge_regs
    import tge_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_HOLD:   cfg_next.hold_time_ms   = pwdata[HOLD_BITS-1:0];
                REG_THR:    cfg_next.move_threshold = pwdata[THR_BITS-1:0];
                REG_WIDTH:  cfg_next.screen_width   = pwdata[SIZE_BITS-1:0];
                REG_HEIGHT: cfg_next.screen_height  = pwdata[SIZE_BITS-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_HOLD:   prdata = DATA_BITS'(cfg_reg.hold_time_ms);
            REG_THR:    prdata = DATA_BITS'(cfg_reg.move_threshold);
            REG_WIDTH:  prdata = DATA_BITS'(cfg_reg.screen_width);
            REG_HEIGHT: prdata = DATA_BITS'(cfg_reg.screen_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_time_ms   <= HOLD_BITS'(RST_HOLD);
            cfg_reg.move_threshold <= THR_BITS'(RST_THR);
            cfg_reg.screen_width   <= SIZE_BITS'(RST_WIDTH);
            cfg_reg.screen_height  <= SIZE_BITS'(RST_HEIGHT);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tge_core.sv]
// ----------------------------------------------------------------------------
// tge_core
// Gesture state and per-sample decode into a bundle of up to three events.
// ----------------------------------------------------------------------------
`default_nettype none

module tge_core
    import tge_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire logic                  step,
    input  wire logic                  touching,
    input  wire logic [COORD_BITS-1:0] tx,
    input  wire logic [COORD_BITS-1:0] ty,
    input  wire logic [TIME_BITS-1:0]  now,
    output bundle_t                    bundle
);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PENDING = 2'd1,
        MODE_MOVE    = 2'd2,
        MODE_DRAG    = 2'd3
    } mode_t;

    mode_t                  mode_reg,   mode_next;
    logic [CUR_BITS-1:0]    cur_x_reg,  cur_x_next;
    logic [CUR_BITS-1:0]    cur_y_reg,  cur_y_next;
    logic [COORD_BITS-1:0]  anc_x_reg,  anc_x_next;
    logic [COORD_BITS-1:0]  anc_y_reg,  anc_y_next;
    logic [COORD_BITS-1:0]  down_x_reg, down_x_next;
    logic [COORD_BITS-1:0]  down_y_reg, down_y_next;
    logic [TIME_BITS-1:0]   down_t_reg, down_t_next;

    logic signed [COORD_BITS:0]   mdx, mdy, adx, ady, dx, dy;
    logic [COORD_BITS-1:0]        mag_x, mag_y;
    logic                         moved, held, nonzero;
    logic [TIME_BITS-1:0]         elapsed;
    logic signed [COORD_BITS+1:0] sum_x, sum_y;
    logic [CUR_BITS-1:0]          lim_x, lim_y, new_x, new_y;
    mode_t                        eff_mode;
    logic                         hold_ev, motion, tap, up_only;
    event_t                       ev_old_move, ev_old_down, ev_old_up, ev_new_move;

    // pending touch: distance from the down point and time since touch-down
    assign mdx     = $signed({1'b0, tx}) - $signed({1'b0, down_x_reg});
    assign mdy     = $signed({1'b0, ty}) - $signed({1'b0, down_y_reg});
    assign mag_x   = mdx[COORD_BITS] ? COORD_BITS'(-mdx) : mdx[COORD_BITS-1:0];
    assign mag_y   = mdy[COORD_BITS] ? COORD_BITS'(-mdy) : mdy[COORD_BITS-1:0];
    assign moved   = (mag_x > COORD_BITS'(cfg.move_threshold))
                  || (mag_y > COORD_BITS'(cfg.move_threshold));
    assign elapsed = now - down_t_reg;
    assign held    = elapsed >= TIME_BITS'(cfg.hold_time_ms);

    // motion: scaled anchor delta added to the cursor, clamped per axis
    assign adx     = $signed({1'b0, tx}) - $signed({1'b0, anc_x_reg});
    assign ady     = $signed({1'b0, ty}) - $signed({1'b0, anc_y_reg});
    assign dx      = scale_div(adx);
    assign dy      = scale_div(ady);
    assign nonzero = (dx != '0) || (dy != '0);
    assign sum_x   = $signed({{(COORD_BITS+2-CUR_BITS){1'b0}}, cur_x_reg})
                   + (COORD_BITS+2)'(dx);
    assign sum_y   = $signed({{(COORD_BITS+2-CUR_BITS){1'b0}}, cur_y_reg})
                   + (COORD_BITS+2)'(dy);
    assign lim_x   = axis_limit(cfg.screen_width);
    assign lim_y   = axis_limit(cfg.screen_height);

    always_comb begin
        if (sum_x < 0) begin
            new_x = '0;
        end else if (sum_x > $signed({{(COORD_BITS+2-CUR_BITS){1'b0}}, lim_x})) begin
            new_x = lim_x;
        end else begin
            new_x = sum_x[CUR_BITS-1:0];
        end
        if (sum_y < 0) begin
            new_y = '0;
        end else if (sum_y > $signed({{(COORD_BITS+2-CUR_BITS){1'b0}}, lim_y})) begin
            new_y = lim_y;
        end else begin
            new_y = sum_y[CUR_BITS-1:0];
        end
    end

    always_comb begin
        eff_mode = mode_reg;
        hold_ev  = 1'b0;
        if (touching) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    eff_mode = MODE_PENDING;
                end
                MODE_PENDING: begin
                    if (moved) begin
                        eff_mode = MODE_MOVE;
                    end else if (held) begin
                        eff_mode = MODE_DRAG;
                        hold_ev  = 1'b1;
                    end
                end
                default: eff_mode = mode_reg;
            endcase
        end else begin
            eff_mode = MODE_IDLE;
        end
    end

    assign motion  = touching && nonzero
                  && ((eff_mode == MODE_MOVE) || (eff_mode == MODE_DRAG));
    assign tap     = !touching && (mode_reg == MODE_PENDING);
    assign up_only = !touching && (mode_reg == MODE_DRAG);

    assign ev_old_move = '{kind: EV_MOVE, x: cur_x_reg, y: cur_y_reg};
    assign ev_old_down = '{kind: EV_DOWN, x: cur_x_reg, y: cur_y_reg};
    assign ev_old_up   = '{kind: EV_UP,   x: cur_x_reg, y: cur_y_reg};
    assign ev_new_move = '{kind: EV_MOVE, x: new_x,     y: new_y};

    always_comb begin
        bundle = '0;
        if (tap) begin
            bundle.count = CNT_BITS'(3);
            bundle.ev[0] = ev_old_move;
            bundle.ev[1] = ev_old_down;
            bundle.ev[2] = ev_old_up;
        end else if (up_only) begin
            bundle.count = CNT_BITS'(1);
            bundle.ev[0] = ev_old_up;
        end else begin
            if (hold_ev) begin
                bundle.ev[0] = ev_old_move;
                bundle.ev[1] = ev_old_down;
                bundle.count = CNT_BITS'(2);
            end
            if (motion) begin
                bundle.ev[hold_ev ? 2 : 0] = ev_new_move;
                bundle.count = bundle.count + CNT_BITS'(1);
            end
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        anc_x_next  = anc_x_reg;
        anc_y_next  = anc_y_reg;
        down_x_next = down_x_reg;
        down_y_next = down_y_reg;
        down_t_next = down_t_reg;
        if (step) begin
            mode_next = eff_mode;
            if (touching && (mode_reg == MODE_IDLE)) begin
                anc_x_next  = tx;
                anc_y_next  = ty;
                down_x_next = tx;
                down_y_next = ty;
                down_t_next = now;
            end
            if (motion) begin
                cur_x_next = new_x;
                cur_y_next = new_y;
                anc_x_next = tx;
                anc_y_next = ty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            cur_x_reg  <= CUR_BITS'(RST_CUR_X);
            cur_y_reg  <= CUR_BITS'(RST_CUR_Y);
            anc_x_reg  <= '0;
            anc_y_reg  <= '0;
            down_x_reg <= '0;
            down_y_reg <= '0;
            down_t_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            anc_x_reg  <= anc_x_next;
            anc_y_reg  <= anc_y_next;
            down_x_reg <= down_x_next;
            down_y_reg <= down_y_next;
            down_t_reg <= down_t_next;
        end
    end

endmodule

`default_nettype wire

[tb/gesture_event_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gesture_event_checker
// Predicts and checks the pointer events of the trackpad gesture engine.
// ----------------------------------------------------------------------------
// Follows register writes on the configuration port and runs every accepted
// touch sample through a decoder of its own: gesture mode, down point and
// time, movement anchor and clamped cursor. The pointer events it predicts
// are queued in order; each result beat is compared field by field with the
// oldest one. Mismatches and the number of events still owed go to the top.
// ----------------------------------------------------------------------------
module gesture_event_checker
    import tge_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_touching,
    input  logic [COORD_BITS-1:0] s_panel_x,
    input  logic [COORD_BITS-1:0] s_panel_y,
    input  logic [TIME_BITS-1:0]  s_time_ms,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [KIND_BITS-1:0]  m_event_kind,
    input  logic [CUR_BITS-1:0]   m_cursor_x,
    input  logic [CUR_BITS-1:0]   m_cursor_y,
    input  logic                  m_last_event,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output int                    mismatches,
    output int                    events_outstanding
);

    typedef enum logic [1:0] {
        GM_IDLE    = 2'd0,
        GM_PENDING = 2'd1,
        GM_MOVE    = 2'd2,
        GM_DRAG    = 2'd3
    } gesture_mode_t;

    typedef struct {
        ev_kind_t            kind;
        logic [CUR_BITS-1:0] x;
        logic [CUR_BITS-1:0] y;
        logic                last;
    } pointer_event_t;

    pointer_event_t owed_events[$];

    logic [HOLD_BITS-1:0] hold_ms;
    logic [THR_BITS-1:0]  thr_px;
    logic [SIZE_BITS-1:0] width_px;
    logic [SIZE_BITS-1:0] height_px;

    gesture_mode_t        mode;
    int                   cur_x;
    int                   cur_y;
    int                   anchor_x;
    int                   anchor_y;
    int                   down_x;
    int                   down_y;
    logic [TIME_BITS-1:0] down_ms;

    task automatic report_mismatch(input string what);
        $display("[%0t] event mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int clamp_to_screen(input int pos, input logic [SIZE_BITS-1:0] size);
        int hi;
        if (size == 0) begin
            hi = 0;
        end else if (size > SIZE_MAX) begin
            hi = SIZE_MAX - 1;
        end else begin
            hi = int'(size) - 1;
        end
        if (pos < 0) pos = 0;
        if (pos > hi) pos = hi;
        return pos;
    endfunction

    function automatic pointer_event_t cursor_event(input ev_kind_t kind);
        pointer_event_t ev;
        ev.kind = kind;
        ev.x    = CUR_BITS'(cur_x);
        ev.y    = CUR_BITS'(cur_y);
        ev.last = 1'b0;
        return ev;
    endfunction

    task automatic predict_gesture_events(input logic touch,
                                          input logic [COORD_BITS-1:0] px,
                                          input logic [COORD_BITS-1:0] py,
                                          input logic [TIME_BITS-1:0] now);
        pointer_event_t       burst[$];
        int                   tx;
        int                   ty;
        int                   mdx;
        int                   mdy;
        int                   dx;
        int                   dy;
        logic [TIME_BITS-1:0] elapsed;
        tx = int'(px);
        ty = int'(py);
        if (touch) begin
            if (mode == GM_IDLE) begin
                anchor_x = tx;
                anchor_y = ty;
                down_x   = tx;
                down_y   = ty;
                down_ms  = now;
                mode     = GM_PENDING;
            end else if (mode == GM_PENDING) begin
                mdx = tx - down_x;
                mdy = ty - down_y;
                if (mdx < 0) mdx = -mdx;
                if (mdy < 0) mdy = -mdy;
                elapsed = now - down_ms;
                if (mdx > int'(thr_px) || mdy > int'(thr_px)) begin
                    mode = GM_MOVE;
                end else if (elapsed >= TIME_BITS'(hold_ms)) begin
                    burst.push_back(cursor_event(EV_MOVE));
                    burst.push_back(cursor_event(EV_DOWN));
                    mode = GM_DRAG;
                end
            end
            if (mode == GM_MOVE || mode == GM_DRAG) begin
                dx = (tx - anchor_x) / PANEL_SCALE;
                dy = (ty - anchor_y) / PANEL_SCALE;
                if (dx != 0 || dy != 0) begin
                    cur_x = clamp_to_screen(cur_x + dx, width_px);
                    cur_y = clamp_to_screen(cur_y + dy, height_px);
                    burst.push_back(cursor_event(EV_MOVE));
                    anchor_x = tx;
                    anchor_y = ty;
                end
            end
        end else begin
            if (mode == GM_PENDING) begin
                burst.push_back(cursor_event(EV_MOVE));
                burst.push_back(cursor_event(EV_DOWN));
                burst.push_back(cursor_event(EV_UP));
            end else if (mode == GM_DRAG) begin
                burst.push_back(cursor_event(EV_UP));
            end
            mode = GM_IDLE;
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) owed_events.push_back(burst[i]);
    endtask

    always @(posedge aclk) begin
        pointer_event_t want;
        if (!aresetn) begin
            hold_ms   = HOLD_BITS'(RST_HOLD);
            thr_px    = THR_BITS'(RST_THR);
            width_px  = SIZE_BITS'(RST_WIDTH);
            height_px = SIZE_BITS'(RST_HEIGHT);
            mode      = GM_IDLE;
            cur_x     = RST_CUR_X;
            cur_y     = RST_CUR_Y;
            anchor_x  = 0;
            anchor_y  = 0;
            down_x    = 0;
            down_y    = 0;
            down_ms   = '0;
            owed_events.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat kind %0d at (%0d,%0d) last %0d",
                        m_event_kind, m_cursor_x, m_cursor_y, m_last_event));
                end else begin
                    want = owed_events.pop_front();
                    if (m_event_kind !== want.kind)
                        report_mismatch($sformatf("event_kind got %0d want %0d",
                            m_event_kind, want.kind));
                    if (m_cursor_x !== want.x)
                        report_mismatch($sformatf("cursor_x got %0d want %0d",
                            m_cursor_x, want.x));
                    if (m_cursor_y !== want.y)
                        report_mismatch($sformatf("cursor_y got %0d want %0d",
                            m_cursor_y, want.y));
                    if (m_last_event !== want.last)
                        report_mismatch($sformatf("last_event got %0d want %0d",
                            m_last_event, want.last));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_HOLD:   hold_ms   = pwdata[HOLD_BITS-1:0];
                    REG_THR:    thr_px    = pwdata[THR_BITS-1:0];
                    REG_WIDTH:  width_px  = pwdata[SIZE_BITS-1:0];
                    REG_HEIGHT: height_px = pwdata[SIZE_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_gesture_events(s_touching, s_panel_x, s_panel_y, s_time_ms);
        end
        events_outstanding = owed_events.size();
    end

endmodule

[tb/trackpad_gesture_engine_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trackpad_gesture_engine_unit_tb
// Touch sample stimulus and verdict for the trackpad gesture engine.
// ----------------------------------------------------------------------------
// Drives touch samples into the engine and takes its pointer events while the
// checker beside it predicts and compares. A directed run covers taps, holds,
// drags, moves, clamping at both screen edges, sub-scale deltas and timestamp
// wrap; random touch sequences follow under several register settings,
// including the extremes and out-of-range screen sizes, with idle cycles on
// either side, a long result stall and a full drain in between.
// ----------------------------------------------------------------------------
module trackpad_gesture_engine_unit_tb;
    import tge_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RX_HOLD_OFF   = 300;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    typedef enum logic [1:0] {
        TAP_STYLE   = 2'd0,
        HOLD_STYLE  = 2'd1,
        SWIPE_STYLE = 2'd2
    } touch_style_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic                  s_touching = 1'b0;
    logic [COORD_BITS-1:0] s_panel_x  = '0;
    logic [COORD_BITS-1:0] s_panel_y  = '0;
    logic [TIME_BITS-1:0]  s_time_ms  = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [KIND_BITS-1:0]  m_event_kind;
    logic [CUR_BITS-1:0]   m_cursor_x;
    logic [CUR_BITS-1:0]   m_cursor_y;
    logic                  m_last_event;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [ADDR_BITS-1:0]  paddr      = '0;
    logic [DATA_BITS-1:0]  pwdata     = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    int                    mismatches;
    int                    events_outstanding;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    bit                    rx_hold_req = 1'b0;
    int                    samples_sent = 0;
    logic [HOLD_BITS-1:0]  hold_cfg;
    logic [THR_BITS-1:0]   thr_cfg;
    logic [TIME_BITS-1:0]  clock_ms;

    trackpad_gesture_engine_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_touching   (s_touching),
        .s_panel_x    (s_panel_x),
        .s_panel_y    (s_panel_y),
        .s_time_ms    (s_time_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_kind (m_event_kind),
        .m_cursor_x   (m_cursor_x),
        .m_cursor_y   (m_cursor_y),
        .m_last_event (m_last_event),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    gesture_event_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_touching         (s_touching),
        .s_panel_x          (s_panel_x),
        .s_panel_y          (s_panel_y),
        .s_time_ms          (s_time_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_cursor_x         (m_cursor_x),
        .m_cursor_y         (m_cursor_y),
        .m_last_event       (m_last_event),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .mismatches         (mismatches),
        .events_outstanding (events_outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // result side: random back-pressure, or a long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                hold_left   = RX_HOLD_OFF;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] no beat for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic offer_sample(input logic touch, input int x, input int y,
                                input logic [TIME_BITS-1:0] ms);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_touching <= touch;
        s_panel_x  <= COORD_BITS'(x);
        s_panel_y  <= COORD_BITS'(y);
        s_time_ms  <= ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (events_outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [HOLD_BITS-1:0] hold, input logic [THR_BITS-1:0] thr,
                              input logic [SIZE_BITS-1:0] width,
                              input logic [SIZE_BITS-1:0] height);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_HOLD, DATA_BITS'(hold));
        write_reg(REG_THR, DATA_BITS'(thr));
        write_reg(REG_WIDTH, DATA_BITS'(width));
        write_reg(REG_HEIGHT, DATA_BITS'(height));
        hold_cfg = hold;
        thr_cfg  = thr;
    endtask

    function automatic int wander(input int pos, input int span);
        int v;
        v = pos + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    task automatic run_gestures(input int count);
        int           goal;
        int           x;
        int           y;
        touch_style_t style;
        goal = samples_sent + count;
        while (samples_sent < goal) begin
            clock_ms += $urandom_range(1, 200);
            if ($urandom_range(9) < 2) begin
                offer_sample(1'($urandom_range(1)), $urandom_range(COORD_MAX),
                             $urandom_range(COORD_MAX), $urandom());
            end else begin
                style = touch_style_t'(2'($urandom_range(2)));
                x = $urandom_range(COORD_MAX);
                y = $urandom_range(COORD_MAX);
                offer_sample(1'b1, x, y, clock_ms);
                repeat ($urandom_range(6)) begin
                    case (style)
                        TAP_STYLE: begin
                            clock_ms += $urandom_range(20);
                            x = wander(x, int'(thr_cfg));
                            y = wander(y, int'(thr_cfg));
                        end
                        HOLD_STYLE: begin
                            if ($urandom_range(3) == 0) begin
                                clock_ms += hold_cfg + $urandom_range(3);
                            end else begin
                                clock_ms += $urandom_range(40);
                            end
                            x = wander(x, int'(thr_cfg));
                            y = wander(y, int'(thr_cfg));
                        end
                        default: begin
                            clock_ms += $urandom_range(1, 30);
                            x = wander(x, 80);
                            y = wander(y, 80);
                        end
                    endcase
                    offer_sample(1'b1, x, y, clock_ms);
                end
                // leave some touches open so the next one lands mid-gesture
                if ($urandom_range(7) != 0) begin
                    clock_ms += $urandom_range(1, 50);
                    offer_sample(1'b0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                                 clock_ms);
                end
            end
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_config(16'd40, 8'd5, 11'd426, 11'd240);
        offer_sample(1'b1, 100, 100, 32'd1000);
        offer_sample(1'b0, 0, 0, 32'd1010);
        offer_sample(1'b0, COORD_MAX, COORD_MAX, 32'd1020);
        offer_sample(1'b1, COORD_MAX, COORD_MAX, 32'd2000);
        offer_sample(1'b1, COORD_MAX, COORD_MAX, 32'd2040);
        offer_sample(1'b1, 0, 0, 32'd2050);
        offer_sample(1'b1, 2, 2, 32'd2060);
        offer_sample(1'b1, 4, 4, 32'd2070);
        offer_sample(1'b0, 4, 4, 32'd2080);
        offer_sample(1'b1, 2000, 2000, 32'd3000);
        offer_sample(1'b1, 2006, 2000, 32'd3001);
        offer_sample(1'b1, 2000, COORD_MAX, 32'd3002);
        offer_sample(1'b0, 2000, COORD_MAX, 32'd3003);
        offer_sample(1'b1, 500, 500, 32'd4000);
        offer_sample(1'b1, 505, 503, 32'd4040);
        offer_sample(1'b0, 505, 503, 32'd4050);
        offer_sample(1'b1, 10, 10, 32'hFFFF_FFF0);
        offer_sample(1'b1, 10, 10, 32'h0000_0020);
        offer_sample(1'b0, 10, 10, 32'hFFFF_FFFF);
        offer_sample(1'b1, 300, 300, 32'd5000);
        offer_sample(1'b1, 295, 305, 32'd5001);
        offer_sample(1'b1, 294, 300, 32'd5002);
        offer_sample(1'b1, COORD_MAX, 0, 32'd5003);
        offer_sample(1'b0, 0, COORD_MAX, 32'd5004);

        tx_idle_pct = 8;
        rx_idle_pct = 63;
        set_config(16'd150, 8'd5, 11'd426, 11'd240);
        clock_ms = $urandom();
        run_gestures(80);

        tx_idle_pct = 63;
        rx_idle_pct = 8;
        set_config(16'd0, 8'd0, 11'd1, 11'd1);
        run_gestures(80);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(16'hFFFF, 8'hFF, 11'd1024, 11'd1024);
        rx_hold_req = 1'b1;
        run_gestures(40);
        wait_drained();
        run_gestures(40);

        set_config(16'd20, 8'd12, 11'd0, 11'h7FF);
        clock_ms = 32'hFFFF_0000;
        run_gestures(70);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && events_outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
